>>> rtl/core/kabf_pkg.sv
// Shared types, constants and helpers of the angle and bias filter.
`timescale 1ns / 1ps
`default_nettype none
package kabf_pkg;

  localparam int unsigned DtFracBits = 24;
  localparam int unsigned MulAW      = 36;
  localparam int unsigned MulBW      = 33;
  localparam int unsigned MulPW      = MulAW + MulBW;
  localparam int unsigned RndW       = 48;
  localparam int unsigned SumW       = 48;

  localparam logic [3:0] AddrAngleNoise = 4'h0;
  localparam logic [3:0] AddrBiasNoise  = 4'h4;
  localparam logic [3:0] AddrMeasNoise  = 4'h8;

  localparam logic tuser_init   = 1'b0;

  typedef struct packed {
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
    logic                    cov_shift;
  } kabf_mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] x);
    logic signed [31:0] r;
    if (x > SumW'(signed'(32'h7fffffff))) begin
      r = 32'sh7fffffff;
    end else if (x < SumW'(signed'(32'h80000000))) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kalman_angle_bias_filter_unit.sv
// Top level of the two-state angle and gyro bias filter with its sequencer.
//
// channel     dir  handshake              payload
// s_axis      in   tvalid/tready          tdata 88b, tuser action
// m_axis      out  tvalid/tready          tdata 64b
// apb         in   psel/penable/pwrite    three noise registers
//
// An initialize item goes from the input state straight to the output state.
// An update item uses the one shared multiplier (ten products), the
// bit-serial divider (two gains), the input state to take the item and
// the output state to load the output register.
// Reset clears the filter state and loads the default noise values.
// A finished item waits in the output register; the next item is taken meanwhile.
// Hold in the output state while an earlier result still waits.
`timescale 1ns / 1ps
`default_nettype none
module kalman_angle_bias_filter_unit #(
  parameter int unsigned CovFracBits = 28
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [87:0] s_axis_tdata_i,  // measured_angle, gyro_rate, time_step
  input  wire         s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // estimated_angle, estimated_bias
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kabf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_W1, S_M2, S_W2, S_M3, S_W3, S_M4, S_W4,
    S_DIV0, S_WAIT0, S_DIV1, S_WAIT1,
    S_M5, S_W5, S_M6, S_W6, S_M7, S_W7, S_M8, S_W8, S_M9, S_W9, S_M10, S_W10,
    S_OUT
  } state_e;

  state_e state_q;
  logic [30:0] qa_q, qb_q, r_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] z_q, rate_q, y_q, k0_q, k1_q;
  logic [23:0] dt_q;
  logic signed [32:0] t_q;
  logic        m_valid_q;
  logic [63:0] m_data_q;

  kabf_mul_req_t          mreq;
  logic signed [RndW-1:0] rnd;
  logic signed [MulBW-1:0] dt_b;
  logic signed [SumW-1:0] rnd_x;
  logic        div_start, div_done;
  logic signed [31:0] div_num, div_quo;
  logic signed [33:0] s_den;
  logic        s_acc, cfg_wr;

  kabf_mul #(.CovFracBits(CovFracBits)) u_mul (
    .clk_i (clk_i), .req_i (mreq), .rnd_o (rnd)
  );

  kabf_div #(.CovFracBits(CovFracBits)) u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start), .num_i (div_num),
    .den_i (s_den), .done_o (div_done), .quo_o (div_quo)
  );

  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    s_acc           = s_axis_tvalid_i && s_axis_tready_o;
    m_axis_tvalid_o = m_valid_q;
    m_axis_tdata_o  = m_data_q;
    pready          = 1'b1;
    cfg_wr          = psel && penable && pwrite;
    unique case (paddr)
      AddrAngleNoise: prdata = {1'b0, qa_q};
      AddrBiasNoise:  prdata = {1'b0, qb_q};
      AddrMeasNoise:  prdata = {1'b0, r_q};
      default:        prdata = '0;
    endcase
    dt_b  = signed'(MulBW'(dt_q));
    rnd_x = SumW'(rnd);
    s_den = 34'(p00_q) + signed'(34'(r_q));
    div_start = (state_q == S_DIV0) || (state_q == S_DIV1);
    div_num   = (state_q == S_DIV1) ? p10_q : p00_q;
    mreq = '0;
    unique case (state_q)
      S_M1: begin
        mreq.a = MulAW'(33'(rate_q) - 33'(bias_q));
        mreq.b = dt_b;
      end
      S_M2: begin
        mreq.a = MulAW'(p11_q);
        mreq.b = dt_b;
      end
      S_M3: begin
        mreq.a = MulAW'(t_q) - MulAW'(p01_q) - MulAW'(p10_q) + signed'(MulAW'(qa_q));
        mreq.b = dt_b;
      end
      S_M4: begin
        mreq.a = signed'(MulAW'(qb_q));
        mreq.b = dt_b;
      end
      S_M5: begin
        mreq = '{a: MulAW'(k0_q), b: MulBW'(y_q), cov_shift: 1'b1};
      end
      S_M6: begin
        mreq = '{a: MulAW'(k1_q), b: MulBW'(y_q), cov_shift: 1'b1};
      end
      S_M7: begin
        mreq = '{a: MulAW'(k1_q), b: MulBW'(p00_q), cov_shift: 1'b1};
      end
      S_M8: begin
        mreq = '{a: MulAW'(k1_q), b: MulBW'(p01_q), cov_shift: 1'b1};
      end
      S_M9: begin
        mreq = '{a: MulAW'(k0_q), b: MulBW'(p00_q), cov_shift: 1'b1};
      end
      S_M10: begin
        mreq = '{a: MulAW'(k0_q), b: MulBW'(p01_q), cov_shift: 1'b1};
      end
      default: mreq = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      qa_q      <= 31'd268435;
      qb_q      <= 31'd805306;
      r_q       <= 31'd8053064;
      ang_q     <= '0;
      bias_q    <= '0;
      p00_q     <= '0;
      p01_q     <= '0;
      p10_q     <= '0;
      p11_q     <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr)
          AddrAngleNoise: qa_q <= pwdata[30:0];
          AddrBiasNoise:  qb_q <= pwdata[30:0];
          AddrMeasNoise:  r_q  <= pwdata[30:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready_i && state_q != S_OUT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            z_q    <= s_axis_tdata_i[31:0];
            rate_q <= s_axis_tdata_i[63:32];
            dt_q   <= s_axis_tdata_i[87:64];
            if (s_axis_tuser_i == tuser_init) begin
              ang_q   <= s_axis_tdata_i[31:0];
              bias_q  <= '0;
              p00_q   <= '0;
              p01_q   <= '0;
              p10_q   <= '0;
              p11_q   <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_M1;
            end
          end
        end
        S_M1:  state_q <= S_W1;
        S_W1: begin
          ang_q   <= sat32(SumW'(ang_q) + rnd_x);
          state_q <= S_M2;
        end
        S_M2:  state_q <= S_W2;
        S_W2: begin
          t_q     <= rnd[32:0];
          state_q <= S_M3;
        end
        S_M3:  state_q <= S_W3;
        S_W3: begin
          p00_q   <= sat32(SumW'(p00_q) + rnd_x);
          p01_q   <= sat32(SumW'(p01_q) - SumW'(t_q));
          p10_q   <= sat32(SumW'(p10_q) - SumW'(t_q));
          state_q <= S_M4;
        end
        S_M4:  state_q <= S_W4;
        S_W4: begin
          p11_q   <= sat32(SumW'(p11_q) + rnd_x);
          state_q <= S_DIV0;
        end
        S_DIV0: begin
          y_q     <= sat32(SumW'(z_q) - SumW'(ang_q));
          state_q <= S_WAIT0;
        end
        S_WAIT0: begin
          if (div_done) begin
            k0_q    <= div_quo;
            state_q <= S_DIV1;
          end
        end
        S_DIV1: state_q <= S_WAIT1;
        S_WAIT1: begin
          if (div_done) begin
            k1_q    <= div_quo;
            state_q <= S_M5;
          end
        end
        S_M5:  state_q <= S_W5;
        S_W5: begin
          ang_q   <= sat32(SumW'(ang_q) + rnd_x);
          state_q <= S_M6;
        end
        S_M6:  state_q <= S_W6;
        S_W6: begin
          bias_q  <= sat32(SumW'(bias_q) + rnd_x);
          state_q <= S_M7;
        end
        S_M7:  state_q <= S_W7;
        S_W7: begin
          p10_q   <= sat32(SumW'(p10_q) - rnd_x);
          state_q <= S_M8;
        end
        S_M8:  state_q <= S_W8;
        S_W8: begin
          p11_q   <= sat32(SumW'(p11_q) - rnd_x);
          state_q <= S_M9;
        end
        S_M9:  state_q <= S_W9;
        S_W9: begin
          p00_q   <= sat32(SumW'(p00_q) - rnd_x);
          state_q <= S_M10;
        end
        S_M10: state_q <= S_W10;
        S_W10: begin
          p01_q   <= sat32(SumW'(p01_q) - rnd_x);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {bias_q, ang_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_WAIT0 || state_q == S_WAIT1))
    else $error("divider finished outside a wait state");

  a_init_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser_i == tuser_init) |=> (state_q == S_OUT))
    else $error("initialize item did not go straight to output");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

endmodule
`default_nettype wire

>>> rtl/core/kabf_mul.sv
// Shared signed multiplier with registered product and rounding shift.
`timescale 1ns / 1ps
`default_nettype none
module kabf_mul #(
  parameter int unsigned CovFracBits = 28
) (
  input  wire                          clk_i,
  input  wire kabf_pkg::kabf_mul_req_t req_i,
  output logic signed [kabf_pkg::RndW-1:0] rnd_o
);
  import kabf_pkg::*;

  logic signed [MulPW-1:0] prod_q;
  logic                    cov_q;
  logic signed [MulPW-1:0] r_dt;
  logic signed [MulPW-1:0] r_cov;

  always_ff @(posedge clk_i) begin
    prod_q <= MulPW'(req_i.a) * MulPW'(req_i.b);
    cov_q  <= req_i.cov_shift;
  end

  always_comb begin
    r_dt  = (prod_q + (MulPW'(1) <<< (DtFracBits - 1))) >>> DtFracBits;
    r_cov = (prod_q + (MulPW'(1) <<< (CovFracBits - 1))) >>> CovFracBits;
    rnd_o = cov_q ? r_cov[RndW-1:0] : r_dt[RndW-1:0];
  end

endmodule
`default_nettype wire

>>> rtl/core/kabf_div.sv
// Bit-serial rounded and saturated gain divider.
`timescale 1ns / 1ps
`default_nettype none
module kabf_div #(
  parameter int unsigned CovFracBits = 28
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire signed [31:0] num_i,
  input  wire signed [33:0] den_i,
  output logic              done_o,
  output logic signed [31:0] quo_o
);
  localparam int unsigned NW = 33 + CovFracBits;

  logic [32:0]   num_mag;
  logic [33:0]   den_mag;
  logic [NW-1:0] dividend;
  logic          ovf;
  logic [34:0]   trial;
  logic          ge;

  logic          busy_q, done_q, neg_q, ovf_q, zero_q;
  logic [34:0]   rem_q;
  logic [31:0]   lo_q;
  logic [4:0]    cnt_q;
  logic [33:0]   den_q;

  always_comb begin
    num_mag  = num_i[31] ? 33'(-33'(num_i)) : 33'(num_i);
    den_mag  = den_i[33] ? 34'(-den_i) : 34'(den_i);
    dividend = NW'({num_mag[31:0], {CovFracBits{1'b0}}}) + NW'(den_mag >> 1);
    ovf      = 34'(dividend[NW-1:32]) >= den_mag;
    trial    = {rem_q[33:0], lo_q[31]};
    ge       = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= 35'(dividend[NW-1:32]);
      lo_q   <= dividend[31:0];
      den_q  <= den_mag;
      neg_q  <= num_i[31] ^ den_i[33];
      ovf_q  <= ovf;
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
      lo_q  <= {lo_q[30:0], ge};
    end
  end

  always_comb begin
    done_o = done_q;
    if (zero_q) begin
      quo_o = '0;
    end else if (neg_q) begin
      quo_o = (ovf_q || lo_q > 32'h80000000) ? 32'sh80000000 : signed'(-lo_q);
    end else begin
      quo_o = (ovf_q || lo_q[31]) ? 32'sh7fffffff : signed'(lo_q);
    end
  end

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for the angle and gyro bias filter: streams items, predicts results, checks them.
`timescale 1ns / 1ps

class kabf_scoreboard;
  logic [63:0] want_q[$];
  int          errors;

  function void note_item(logic [63:0] r);
    want_q.push_back(r);
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_result(logic [63:0] got);
    logic [63:0] w;
    if (want_q.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    w = want_q.pop_front();
    if (got[31:0] !== w[31:0]) begin
      report($sformatf("estimated_angle got %h want %h", got[31:0], w[31:0]));
    end
    if (got[63:32] !== w[63:32]) begin
      report($sformatf("estimated_bias got %h want %h", got[63:32], w[63:32]));
    end
  endtask
endclass

module tb;
  import kabf_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [87:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  localparam logic ActInit   = 1'b0;
  localparam logic ActUpdate = 1'b1;

  int send_idle_pct = 33;
  int recv_idle_pct = 62;

  kabf_scoreboard board;

  longint noise_angle, noise_bias, noise_meas;
  int     ang, bia, p00, p01, p10, p11;

  kalman_angle_bias_filter_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic int clip32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return int'(x);
  endfunction

  // Round to nearest, ties toward plus infinity; >>> floors.
  function automatic longint rnd_shift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic int gain(int num, longint den);
    longint n;
    longint unsigned un, ud, q;
    bit neg;
    if (den == 0) return 0;
    n = longint'(num) <<< 28;
    neg = (n < 0) != (den < 0);
    un = n < 0 ? -n : n;
    ud = den < 0 ? -den : den;
    q = (un + ud / 2) / ud;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return clip32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic logic [63:0] filter_predict(logic act, int z, int rate,
                                                 logic [23:0] dt_u);
    longint dt, t, inner, s, y;
    int k0, k1, o00, o01;
    if (act == ActInit) begin
      ang = z; bia = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    end else begin
      dt = longint'(dt_u);
      ang = clip32(longint'(ang) + rnd_shift((longint'(rate) - bia) * dt, 24));
      t = rnd_shift(longint'(p11) * dt, 24);
      inner = t - p01 - p10 + noise_angle;
      p00 = clip32(longint'(p00) + rnd_shift(inner * dt, 24));
      p01 = clip32(longint'(p01) - t);
      p10 = clip32(longint'(p10) - t);
      p11 = clip32(longint'(p11) + rnd_shift(noise_bias * dt, 24));
      s = longint'(p00) + noise_meas;
      k0 = gain(p00, s);
      k1 = gain(p10, s);
      y = clip32(longint'(z) - ang);
      ang = clip32(longint'(ang) + rnd_shift(longint'(k0) * y, 28));
      bia = clip32(longint'(bia) + rnd_shift(longint'(k1) * y, 28));
      o00 = p00; o01 = p01;
      p00 = clip32(longint'(p00) - rnd_shift(longint'(k0) * o00, 28));
      p01 = clip32(longint'(p01) - rnd_shift(longint'(k0) * o01, 28));
      p10 = clip32(longint'(p10) - rnd_shift(longint'(k1) * o00, 28));
      p11 = clip32(longint'(p11) - rnd_shift(longint'(k1) * o01, 28));
    end
    return {bia, ang};
  endfunction

  task automatic write_reg(logic [3:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      AddrAngleNoise: noise_angle = val[30:0];
      AddrBiasNoise:  noise_bias  = val[30:0];
      AddrMeasNoise:  noise_meas  = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_noise(logic [31:0] qa, logic [31:0] qb, logic [31:0] r);
    write_reg(AddrAngleNoise, qa);
    write_reg(AddrBiasNoise, qb);
    write_reg(AddrMeasNoise, r);
  endtask

  task automatic send_item(logic act, int z, int rate, logic [23:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {dt, rate, z};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_item(filter_predict(act, z, rate, dt));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic int rand_angle();
    case ($urandom_range(3))
      0: return $urandom;
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
    endcase
  endfunction

  task automatic random_run(int n);
    logic [23:0] dt;
    for (int i = 0; i < n; i++) begin
      dt = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h0fffff));
      if ($urandom_range(24) == 0) send_item(ActInit, rand_angle(), $urandom, 24'($urandom));
      else send_item(ActUpdate, rand_angle(), rand_angle(), dt);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    board = new();
    noise_angle = 268435; noise_bias = 805306; noise_meas = 8053064;
    ang = 0; bia = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: defaults, extremes, zero divisor, large gain and innovation.
    send_item(ActUpdate, 32'h00010000, 32'h00020000, 24'h010000);
    send_item(ActInit, 32'h7fffffff, 32'hffffffff, 24'hffffff);
    send_item(ActUpdate, 32'h80000000, 32'h7fffffff, 24'hffffff);
    send_item(ActUpdate, 32'h7fffffff, 32'h80000000, 24'hffffff);
    send_item(ActUpdate, 32'h00000000, 32'h00000000, 24'h000000);
    send_item(ActInit, 32'h80000000, 32'h0, 24'h0);
    send_item(ActUpdate, 32'h7fffffff, 32'h7fffffff, 24'h800000);
    drain();
    set_noise(32'h0, 32'h0, 32'h0);
    send_item(ActInit, 32'h00050000, 32'h0, 24'h0);
    send_item(ActUpdate, 32'h00060000, 32'h00010000, 24'h000000);
    send_item(ActUpdate, 32'h00060000, 32'h00010000, 24'h100000);
    drain();
    set_noise(32'hffffffff, 32'hffffffff, 32'h0);
    send_item(ActUpdate, 32'h7fffffff, 32'h80000000, 24'hffffff);
    send_item(ActUpdate, 32'h80000000, 32'h7fffffff, 24'hffffff);
    send_item(ActUpdate, 32'h12345678, 32'hedcba987, 24'h555555);
    send_item(ActInit, 32'hffff0000, 32'h0, 24'h0);
    send_item(ActUpdate, 32'h00000001, 32'hfffffffe, 24'haaaaaa);
    drain();
    set_noise(32'd268435, 32'd805306, 32'd8053064);

    random_run(320);
    drain();
    send_idle_pct = 62; recv_idle_pct = 33;
    set_noise($urandom, $urandom, $urandom);
    random_run(320);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_noise($urandom_range(0, 32'h00ffffff), $urandom_range(0, 32'h00ffffff),
              $urandom_range(1, 32'h0fffffff));
    random_run(310);
    drain();

    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
